@@ rtl/dcto_pkg.sv @@
// ----------------------------------------------------------------------------
// dcto_pkg: shared types and constants of the speed controller
// Widths of the Q16.16 quantities, register codes and reset values,
// controller states and the command set passed to the datapath.
// ----------------------------------------------------------------------------
package dcto_pkg;

  localparam int HISTORY_DEPTH = 4;

  localparam int FRAC_W   = 16;
  localparam int DIST_W   = 32;
  localparam int CMD_W    = 23;
  localparam int LIM_W    = 23;
  localparam int TICK_W   = 17;
  localparam int PHASE_W  = 2;

  // Sum of the history of commands.
  localparam int SUM_W    = CMD_W + $clog2(HISTORY_DEPTH);
  // Speed step per tick (limit times period).
  localparam int STEP_W   = LIM_W + TICK_W - FRAC_W;
  // Accelerated speed: newest command plus one step.
  localparam int V1_W     = STEP_W + 1;
  localparam int TRAVEL_W = SUM_W + TICK_W - FRAC_W;
  localparam int T1_W     = V1_W + TICK_W - FRAC_W;
  // Twice the deceleration limit.
  localparam int DIV_W    = LIM_W + 1;
  localparam int K_W      = DIST_W + 1;
  localparam int SQ_W     = 2 * V1_W;

  // Shared multiplier operands and product.
  localparam int MUL_A_W  = DIST_W - 1;
  localparam int MUL_B_W  = (V1_W > DIV_W) ? V1_W : DIV_W;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int PSH_W    = PROD_W - FRAC_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LIM_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL_LIMIT = 2'd0,
    CFG_DECEL_LIMIT = 2'd1,
    CFG_SPEED_LIMIT = 2'd2,
    CFG_TICK_PERIOD = 2'd3
  } cfg_idx_e;

  localparam logic [LIM_W-1:0]  ACCEL_RESET = LIM_W'(262144);
  localparam logic [LIM_W-1:0]  DECEL_RESET = LIM_W'(262144);
  localparam logic [LIM_W-1:0]  SPEED_RESET = LIM_W'(65536);
  localparam logic [TICK_W-1:0] TICK_RESET  = TICK_W'(3277);

  typedef enum logic [PHASE_W-1:0] {
    PH_STOP   = 2'd0,
    PH_ACCEL  = 2'd1,
    PH_CRUISE = 2'd2,
    PH_DECEL  = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRAVEL,
    ST_UP,
    ST_DOWN,
    ST_T1,
    ST_K1,
    ST_SQ1,
    ST_CMP1,
    ST_SQ0,
    ST_CMP0,
    ST_DONE
  } ctrl_state_e;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_TRAVEL,
    MUL_UP,
    MUL_DOWN,
    MUL_T1,
    MUL_SQ1,
    MUL_K1B,
    MUL_SQ0,
    MUL_CB
  } mul_op_e;

  // Which datapath register takes the previous product.
  typedef enum logic [3:0] {
    CAP_NONE,
    CAP_COMP,
    CAP_V1,
    CAP_DOWN,
    CAP_K1,
    CAP_SQ,
    CAP_ACC,
    CAP_CRU
  } cap_e;

  typedef struct packed {
    logic    load_in;
    mul_op_e mul_op;
    cap_e    cap;
    logic    finish;
  } ctrl_cmd_t;

endpackage

@@ rtl/dcto_in_if.sv @@
// ----------------------------------------------------------------------------
// dcto_in_if: input channel
// Valid/ready channel carrying the distance to the stop point.
// ----------------------------------------------------------------------------
interface dcto_in_if;
  import dcto_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DIST_W-1:0] distance_to_go;

  modport source (output valid, output distance_to_go, input ready);
  modport sink   (input valid, input distance_to_go, output ready);
endinterface

@@ rtl/dcto_out_if.sv @@
// ----------------------------------------------------------------------------
// dcto_out_if: result channel
// Valid/ready channel carrying the speed command, the compensated distance
// and the control phase.
// ----------------------------------------------------------------------------
interface dcto_out_if;
  import dcto_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         speed_command;
  logic signed [DIST_W-1:0] compensated_distance;
  logic [PHASE_W-1:0]       phase;

  modport source (output valid, output speed_command, output compensated_distance,
                  output phase, input ready);
  modport sink   (input valid, input speed_command, input compensated_distance,
                  input phase, output ready);
endinterface

@@ rtl/dcto_ctrl.sv @@
// ----------------------------------------------------------------------------
// dcto_ctrl: sequencing controller
// Steps one item through the multiply schedule of the datapath and owns the
// handshake state of both channels.
// ----------------------------------------------------------------------------
module dcto_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dcto_pkg::ctrl_cmd_t cmd_o
);
  import dcto_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_TRAVEL;
      ST_TRAVEL: state_d = ST_UP;
      ST_UP:     state_d = ST_DOWN;
      ST_DOWN:   state_d = ST_T1;
      ST_T1:     state_d = ST_K1;
      ST_K1:     state_d = ST_SQ1;
      ST_SQ1:    state_d = ST_CMP1;
      ST_CMP1:   state_d = ST_SQ0;
      ST_SQ0:    state_d = ST_CMP0;
      ST_CMP0:   state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load_in = 1'b0;
    cmd_o.mul_op  = MUL_NONE;
    cmd_o.cap     = CAP_NONE;
    cmd_o.finish  = 1'b0;
    case (state_q)
      ST_IDLE:   cmd_o.load_in = in_valid_i;
      ST_TRAVEL: cmd_o.mul_op = MUL_TRAVEL;
      ST_UP: begin
        cmd_o.mul_op = MUL_UP;
        cmd_o.cap    = CAP_COMP;
      end
      ST_DOWN: begin
        cmd_o.mul_op = MUL_DOWN;
        cmd_o.cap    = CAP_V1;
      end
      ST_T1: begin
        cmd_o.mul_op = MUL_T1;
        cmd_o.cap    = CAP_DOWN;
      end
      ST_K1: begin
        cmd_o.mul_op = MUL_SQ1;
        cmd_o.cap    = CAP_K1;
      end
      ST_SQ1: begin
        cmd_o.mul_op = MUL_K1B;
        cmd_o.cap    = CAP_SQ;
      end
      ST_CMP1: begin
        cmd_o.mul_op = MUL_SQ0;
        cmd_o.cap    = CAP_ACC;
      end
      ST_SQ0: begin
        cmd_o.mul_op = MUL_CB;
        cmd_o.cap    = CAP_SQ;
      end
      ST_CMP0:   cmd_o.cap = CAP_CRU;
      ST_DONE:   cmd_o.finish = out_free;
      default: begin
        cmd_o.load_in = 1'b0;
      end
    endcase
  end

  // A new result may be loaded in the same cycle as the old one transfers.
  assign out_valid_d = cmd_o.finish ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/dcto_datapath.sv @@
// ----------------------------------------------------------------------------
// dcto_datapath: arithmetic, registers and command history
// One shared multiplier with a registered product serves every product of
// the control law. Stop-distance tests compare v*v against the remaining
// distance times twice the deceleration, so no divider is needed.
// ----------------------------------------------------------------------------
module dcto_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dcto_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dcto_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic signed [dcto_pkg::DIST_W-1:0] distance_to_go_i,
  input  dcto_pkg::ctrl_cmd_t                cmd_i,
  output logic [dcto_pkg::CMD_W-1:0]         speed_command_o,
  output logic signed [dcto_pkg::DIST_W-1:0] compensated_distance_o,
  output logic [dcto_pkg::PHASE_W-1:0]       phase_o
);
  import dcto_pkg::*;

  // Configuration registers.
  logic [LIM_W-1:0]  accel_q, decel_q, speed_q;
  logic [TICK_W-1:0] tick_q;

  // History of commands; the last entry is the newest.
  logic [CMD_W-1:0] hist_q [HISTORY_DEPTH];
  logic [SUM_W-1:0] sum_q;

  // Working registers of one item.
  logic signed [DIST_W-1:0] dist_q, comp_q;
  logic [PROD_W-1:0]        p_q;
  logic [V1_W-1:0]          v1_q;
  logic [STEP_W-1:0]        down_q;
  logic signed [K_W-1:0]    k1_q;
  logic [SQ_W-1:0]          sq_q;
  logic                     acc_ok_q, cru_ok_q;

  // Result registers.
  logic [CMD_W-1:0]         cmd_res_q;
  logic signed [DIST_W-1:0] comp_res_q;
  logic [PHASE_W-1:0]       phase_res_q;

  logic [CMD_W-1:0]     v0;
  logic [DIV_W-1:0]     twice_dec;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [PSH_W-1:0]     p_sh;
  logic [DIST_W+1:0]    comp_wide;
  logic signed [DIST_W-1:0] comp_sat;
  logic signed [K_W-1:0]    k1_d;
  logic                 k1_pos, comp_pos;
  logic [CMD_W-1:0]     cmd_d;
  phase_e               phase_d;
  logic [SUM_W-1:0]     sum_d;

  assign v0        = hist_q[HISTORY_DEPTH-1];
  // A zero deceleration limit counts as one in the stop distance.
  assign twice_dec = {((decel_q == '0) ? LIM_W'(1) : decel_q), 1'b0};
  assign p_sh      = p_q[PROD_W-1:FRAC_W];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_op)
      MUL_TRAVEL: begin
        mul_a = MUL_A_W'(sum_q);
        mul_b = MUL_B_W'(tick_q);
      end
      MUL_UP: begin
        mul_a = MUL_A_W'(accel_q);
        mul_b = MUL_B_W'(tick_q);
      end
      MUL_DOWN: begin
        mul_a = MUL_A_W'(decel_q);
        mul_b = MUL_B_W'(tick_q);
      end
      MUL_T1: begin
        mul_a = MUL_A_W'(v1_q);
        mul_b = MUL_B_W'(tick_q);
      end
      MUL_SQ1: begin
        mul_a = MUL_A_W'(v1_q);
        mul_b = MUL_B_W'(v1_q);
      end
      MUL_K1B: begin
        mul_a = k1_q[MUL_A_W-1:0];
        mul_b = MUL_B_W'(twice_dec);
      end
      MUL_SQ0: begin
        mul_a = MUL_A_W'(v0);
        mul_b = MUL_B_W'(v0);
      end
      MUL_CB: begin
        mul_a = comp_q[MUL_A_W-1:0];
        mul_b = MUL_B_W'(twice_dec);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Compensated distance, saturated to the signed range of the field.
  always_comb begin
    comp_wide = {{2{dist_q[DIST_W-1]}}, dist_q} - (DIST_W + 2)'(p_sh[TRAVEL_W-1:0]);
    if (comp_wide[DIST_W+1] && (comp_wide[DIST_W:DIST_W-1] != 2'b11)) begin
      comp_sat = {1'b1, {(DIST_W-1){1'b0}}};
    end else if (!comp_wide[DIST_W+1] && (comp_wide[DIST_W:DIST_W-1] != 2'b00)) begin
      comp_sat = {1'b0, {(DIST_W-1){1'b1}}};
    end else begin
      comp_sat = comp_wide[DIST_W-1:0];
    end
  end

  // Distance left once the accelerated speed has run for one tick.
  assign k1_d     = $signed({comp_q[DIST_W-1], comp_q}) - $signed(K_W'(p_sh[T1_W-1:0]));
  assign k1_pos   = !k1_q[K_W-1] && (k1_q != '0);
  assign comp_pos = !comp_q[DIST_W-1] && (comp_q != '0);

  always_comb begin
    cmd_d   = '0;
    phase_d = PH_STOP;
    if (comp_pos) begin
      if (acc_ok_q) begin
        cmd_d   = v1_q[CMD_W-1:0];
        phase_d = PH_ACCEL;
      end else if (cru_ok_q) begin
        cmd_d   = v0;
        phase_d = PH_CRUISE;
      end else begin
        cmd_d   = (STEP_W'(v0) > down_q) ? CMD_W'(STEP_W'(v0) - down_q) : '0;
        phase_d = PH_DECEL;
      end
    end
  end

  assign sum_d = sum_q - SUM_W'(hist_q[0]) + SUM_W'(cmd_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q <= ACCEL_RESET;
      decel_q <= DECEL_RESET;
      speed_q <= SPEED_RESET;
      tick_q  <= TICK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACCEL_LIMIT: accel_q <= cfg_data_i;
        CFG_DECEL_LIMIT: decel_q <= cfg_data_i;
        CFG_SPEED_LIMIT: speed_q <= cfg_data_i;
        CFG_TICK_PERIOD: tick_q  <= cfg_data_i[TICK_W-1:0];
        default: begin
          accel_q <= accel_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
      sum_q <= '0;
    end else if (cmd_i.finish) begin
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
        hist_q[i] <= hist_q[i+1];
      end
      hist_q[HISTORY_DEPTH-1] <= cmd_d;
      sum_q                   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (cmd_i.load_in) begin
      dist_q <= distance_to_go_i;
    end
    case (cmd_i.cap)
      CAP_COMP: comp_q <= comp_sat;
      CAP_V1:   v1_q   <= V1_W'(v0) + V1_W'(p_sh[STEP_W-1:0]);
      CAP_DOWN: down_q <= p_sh[STEP_W-1:0];
      CAP_K1:   k1_q   <= k1_d;
      CAP_SQ:   sq_q   <= p_q[SQ_W-1:0];
      CAP_ACC:  acc_ok_q <= (v1_q <= V1_W'(speed_q)) && k1_pos &&
                            (PROD_W'(sq_q) < p_q);
      CAP_CRU:  cru_ok_q <= (v0 <= speed_q) && (PROD_W'(sq_q) < p_q);
      default: begin
        sq_q <= sq_q;
      end
    endcase
    if (cmd_i.finish) begin
      cmd_res_q   <= cmd_d;
      comp_res_q  <= comp_q;
      phase_res_q <= phase_d;
    end
  end

  assign speed_command_o        = cmd_res_q;
  assign compensated_distance_o = comp_res_q;
  assign phase_o                = phase_res_q;

endmodule

@@ rtl/delay_compensated_time_optimal_speed.sv @@
// ----------------------------------------------------------------------------
// delay_compensated_time_optimal_speed: latency-compensated speed controller
// Removes the travel still in flight from the distance to go and applies the
// time-optimal accelerate / cruise / decelerate rule to the last command.
//
//   Channel   Role    Transfer when     Carries
//   in_i      sink    valid & ready     distance_to_go
//   out_o     source  valid & ready     speed_command, compensated_distance,
//                                       phase
//   cfg       write   cfg_we_i high     cfg_idx_i, cfg_data_i
//
// An item's result is loaded into the output register once the controller has
// stepped eight products through one shared multiplier, one per cycle. A new
// item is taken only once the controller is back in idle, so items do not
// overlap, while the previous result may still wait. A stalled output holds the
// controller in its final step. Reset is asynchronous and restores the
// register defaults and an empty history.
// ----------------------------------------------------------------------------
module delay_compensated_time_optimal_speed (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dcto_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dcto_pkg::CFG_DATA_W-1:0] cfg_data_i,
  dcto_in_if.sink                         in_i,
  dcto_out_if.source                      out_o
);
  import dcto_pkg::*;

  ctrl_cmd_t cmd;

  dcto_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  dcto_datapath u_datapath (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_data_i             (cfg_data_i),
    .distance_to_go_i       (in_i.distance_to_go),
    .cmd_i                  (cmd),
    .speed_command_o        (out_o.speed_command),
    .compensated_distance_o (out_o.compensated_distance),
    .phase_o                (out_o.phase)
  );

endmodule

@@ sim/delay_compensated_time_optimal_speed_checker.sv @@
// ----------------------------------------------------------------------------
// delay_compensated_time_optimal_speed_checker: result checker
// Watches the register writes and both channels. On every input transfer it
// works out the speed command, compensated distance and phase from its own
// copy of the limits and the command history, and compares each result
// transfer field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module delay_compensated_time_optimal_speed_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  dcto_pkg::cfg_idx_e              cfg_idx_i,
  input  logic [dcto_pkg::CFG_DATA_W-1:0] cfg_data_i,
  dcto_in_if                              in_ch_i,
  dcto_out_if                             out_ch_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              results_o
);
  import dcto_pkg::*;

  localparam longint DIST_MAX = 64'sd2147483647;
  localparam longint DIST_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [CMD_W-1:0]         speed;
    logic signed [DIST_W-1:0] distance;
    phase_e                   phase;
  } speed_result_t;

  logic [LIM_W-1:0]  accel_lim;
  logic [LIM_W-1:0]  decel_lim;
  logic [LIM_W-1:0]  speed_lim;
  logic [TICK_W-1:0] tick_lim;
  logic [31:0]       cmd_hist [HISTORY_DEPTH];
  logic [31:0]       hist_sum;
  speed_result_t     expected_q [$];
  speed_result_t     want;

  // A deceleration limit of zero is taken as one here so the division holds.
  function automatic logic [63:0] braking_distance(input logic [63:0] v);
    logic [63:0] dec;
    dec = (decel_lim == '0) ? 64'd1 : 64'(decel_lim);
    return (v * v) / (2 * dec);
  endfunction

  function automatic speed_result_t control_tick(input logic signed [DIST_W-1:0] dist_in);
    speed_result_t res;
    logic [63:0]   tick, travel, up, down, v0, v1, reach_up, reach_hold, cmd;
    longint        comp;
    phase_e        ph;
    tick   = 64'(tick_lim);
    travel = (64'(hist_sum) * tick) >> FRAC_W;
    comp   = longint'(dist_in) - longint'(travel);
    if (comp > DIST_MAX) begin
      comp = DIST_MAX;
    end else if (comp < DIST_MIN) begin
      comp = DIST_MIN;
    end
    cmd = '0;
    ph  = PH_STOP;
    if (comp > 0) begin
      v0         = 64'(cmd_hist[HISTORY_DEPTH-1]);
      up         = (64'(accel_lim) * tick) >> FRAC_W;
      down       = (64'(decel_lim) * tick) >> FRAC_W;
      v1         = v0 + up;
      reach_up   = ((v1 * tick) >> FRAC_W) + braking_distance(v1);
      reach_hold = braking_distance(v0);
      if (v1 <= 64'(speed_lim) && reach_up < 64'(comp)) begin
        cmd = v1;
        ph  = PH_ACCEL;
      end else if (v0 <= 64'(speed_lim) && reach_hold < 64'(comp)) begin
        cmd = v0;
        ph  = PH_CRUISE;
      end else begin
        cmd = (v0 > down) ? v0 - down : '0;
        ph  = PH_DECEL;
      end
    end
    // Even a stop command enters the history.
    hist_sum = hist_sum - cmd_hist[0] + cmd[31:0];
    for (int i = 0; i < HISTORY_DEPTH - 1; i++) cmd_hist[i] = cmd_hist[i+1];
    cmd_hist[HISTORY_DEPTH-1] = cmd[31:0];
    res.speed    = cmd[CMD_W-1:0];
    res.distance = comp[DIST_W-1:0];
    res.phase    = ph;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_lim    = ACCEL_RESET;
      decel_lim    = DECEL_RESET;
      speed_lim    = SPEED_RESET;
      tick_lim     = TICK_RESET;
      hist_sum     = '0;
      cmd_hist     = '{default: '0};
      expected_q.delete();
      fail_count_o = 0;
      results_o    = 0;
      pending_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ACCEL_LIMIT: accel_lim = cfg_data_i;
          CFG_DECEL_LIMIT: decel_lim = cfg_data_i;
          CFG_SPEED_LIMIT: speed_lim = cfg_data_i;
          CFG_TICK_PERIOD: tick_lim  = cfg_data_i[TICK_W-1:0];
          default: ;
        endcase
      end
      if (in_ch_i.valid && in_ch_i.ready) begin
        expected_q.push_back(control_tick(in_ch_i.distance_to_go));
      end
      if (out_ch_i.valid && out_ch_i.ready) begin
        results_o++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result: speed %0d distance %0d phase %0d",
                   $time, out_ch_i.speed_command, out_ch_i.compensated_distance,
                   out_ch_i.phase);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (out_ch_i.speed_command !== want.speed) begin
            $display("%0t: speed_command expected %0d, got %0d",
                     $time, want.speed, out_ch_i.speed_command);
            fail_count_o++;
          end
          if (out_ch_i.compensated_distance !== want.distance) begin
            $display("%0t: compensated_distance expected %0d, got %0d",
                     $time, want.distance, out_ch_i.compensated_distance);
            fail_count_o++;
          end
          if (out_ch_i.phase !== want.phase) begin
            $display("%0t: phase expected %0d, got %0d",
                     $time, want.phase, out_ch_i.phase);
            fail_count_o++;
          end
        end
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

@@ sim/delay_compensated_time_optimal_speed_test.sv @@
// ----------------------------------------------------------------------------
// delay_compensated_time_optimal_speed_test: testbench top
// Drives distances in bursts, with the receiver stalling on its own pattern,
// over a series of limit settings from the extremes to out-of-range values.
// Most items follow stop-point approaches scaled to the current limits; the
// rest are noise. The checker predicts and compares; this module decides.
// ----------------------------------------------------------------------------
module delay_compensated_time_optimal_speed_test;
  import dcto_pkg::*;

  localparam int HOLD_CYCLES       = 300;
  localparam int STALL_LIMIT       = 4000;
  localparam int ITEMS_PER_SETTING = 50;
  localparam int SETTINGS_COUNT    = 9;
  localparam int PRESSURE_SETTING  = 4;

  localparam logic signed [DIST_W-1:0] DIST_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [DIST_W-1:0] DIST_MIN  = 32'sh8000_0000;
  localparam logic signed [DIST_W-1:0] ONE_METRE = 32'sd65536;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  cfg_idx_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int results_checked;
  int items_sent;
  int idle_cycles;
  int hold_off_reqs;

  logic [LIM_W-1:0]         speed_now;
  logic [TICK_W-1:0]        tick_now;
  logic signed [DIST_W-1:0] plan_q [$];

  dcto_in_if  in_ch ();
  dcto_out_if out_ch ();

  delay_compensated_time_optimal_speed dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  delay_compensated_time_optimal_speed_checker speed_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_ch_i      (in_ch),
    .out_ch_i     (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results_checked)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Nothing transferred on either channel for too long means a hang.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("delay_compensated_time_optimal_speed_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: segments of differing stall rates, plus a long hold-off on request.
  initial begin : receiver
    int seg_len;
    int stall_pct;
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      seg_len = $urandom_range(60, 5);
      case ($urandom_range(3, 0))
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        2:       stall_pct = 60;
        default: stall_pct = 90;
      endcase
      repeat (seg_len) begin
        @(posedge clk_i);
        if (hold_left > 0) begin
          out_ch.ready <= 1'b0;
          hold_left--;
        end else if (hold_off_reqs != holds_done) begin
          holds_done++;
          hold_left    = HOLD_CYCLES;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
        end
      end
    end
  end

  task automatic send_distance(input logic signed [DIST_W-1:0] dist_in);
    in_ch.valid          <= 1'b1;
    in_ch.distance_to_go <= dist_in;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // The pending count is registered, so look only after the next edge.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic send_queued(input bit steady);
    int burst;
    int gap;
    while (plan_q.size() > 0) begin
      burst = $urandom_range(12, 1);
      while (burst > 0 && plan_q.size() > 0) begin
        send_distance(plan_q.pop_front());
        burst--;
      end
      gap = (steady || $urandom_range(3, 0) == 0) ? 0 : $urandom_range(15, 1);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      if (!steady && $urandom_range(19, 0) == 0) wait_drained();
    end
  endtask

  task automatic load_settings(input logic [LIM_W-1:0] accel, input logic [LIM_W-1:0] decel,
                               input logic [LIM_W-1:0] speed, input logic [LIM_W-1:0] tick);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_ACCEL_LIMIT;
    cfg_data <= accel;
    @(posedge clk_i);
    cfg_idx  <= CFG_DECEL_LIMIT;
    cfg_data <= decel;
    @(posedge clk_i);
    cfg_idx  <= CFG_SPEED_LIMIT;
    cfg_data <= speed;
    @(posedge clk_i);
    cfg_idx  <= CFG_TICK_PERIOD;
    cfg_data <= tick;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    speed_now = speed;
    tick_now  = tick[TICK_W-1:0];
  endtask

  initial begin : stimulus
    logic [LIM_W-1:0] acc_w, dec_w, spd_w, tick_w;
    longint           step_len;
    longint           pos;
    int               len;
    rst_ni                = 1'b0;
    hold_off_reqs         = 0;
    items_sent            = 0;
    in_ch.valid          <= 1'b0;
    in_ch.distance_to_go <= '0;
    cfg_we               <= 1'b0;
    cfg_idx              <= CFG_ACCEL_LIMIT;
    cfg_data             <= '0;
    speed_now             = SPEED_RESET;
    tick_now              = TICK_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset limits: stop cases, the largest distance,
    // a ramp to the speed limit and on into cruise, saturation of the
    // compensated distance at the negative end while travel is in flight,
    // then a short distance that forces deceleration down to zero.
    plan_q.push_back('0);
    plan_q.push_back(-32'sd1);
    plan_q.push_back(DIST_MAX);
    repeat (5) plan_q.push_back(10 * ONE_METRE);
    plan_q.push_back(DIST_MIN);
    repeat (3) plan_q.push_back(10 * ONE_METRE);
    repeat (4) plan_q.push_back(32'sd13107);
    plan_q.push_back(32'sd1);
    plan_q.push_back(ONE_METRE);
    plan_q.push_back(-ONE_METRE);
    send_queued(1'b0);
    wait_drained();

    for (int p = 0; p < SETTINGS_COUNT; p++) begin
      case (p)
        0: begin
          acc_w = LIM_W'(4194304); dec_w = LIM_W'(1);
          spd_w = LIM_W'(4194304); tick_w = LIM_W'(65536);
        end
        1: begin
          acc_w = '0; dec_w = LIM_W'(4194304); spd_w = '0; tick_w = LIM_W'(1);
        end
        2: begin
          // Zero deceleration and zero period lie outside the stated ranges.
          acc_w = LIM_W'($urandom_range(4194304, 0)); dec_w = '0;
          spd_w = LIM_W'($urandom_range(4194304, 0)); tick_w = '0;
        end
        3: begin
          acc_w = '1; dec_w = '1; spd_w = '1; tick_w = '1;
        end
        6: begin
          acc_w = LIM_W'($urandom_range(4194304, 0));
          dec_w = LIM_W'($urandom_range(4194304, 1));
          spd_w = LIM_W'($urandom_range(4194304, 0));
          tick_w = LIM_W'($urandom_range(65536, 1));
        end
        7: begin
          acc_w = ACCEL_RESET; dec_w = DECEL_RESET;
          spd_w = SPEED_RESET; tick_w = LIM_W'(TICK_RESET);
        end
        default: begin
          acc_w = LIM_W'($urandom_range(524288, 16384));
          dec_w = LIM_W'($urandom_range(524288, 16384));
          spd_w = LIM_W'($urandom_range(262144, 16384));
          tick_w = LIM_W'($urandom_range(13107, 655));
        end
      endcase
      repeat (4) @(posedge clk_i);
      load_settings(acc_w, dec_w, spd_w, tick_w);

      // Approaches are scaled to the travel of one tick at the speed limit.
      step_len = (longint'(speed_now) * longint'(tick_now)) >>> FRAC_W;
      if (step_len < 1) step_len = 1;
      while (plan_q.size() < ITEMS_PER_SETTING) begin
        if ($urandom_range(3, 0) != 0) begin
          pos = longint'($urandom_range(60, 3)) * step_len
              + longint'($urandom_range(int'(step_len), 0));
          len = $urandom_range(40, 8);
          while (len > 0 && pos >= -step_len) begin
            plan_q.push_back(DIST_W'((pos > longint'(DIST_MAX)) ? longint'(DIST_MAX) : pos));
            pos -= longint'($urandom_range(int'(2 * step_len), 0));
            len--;
          end
        end else begin
          case ($urandom_range(3, 0))
            0:       plan_q.push_back($urandom);
            1:       plan_q.push_back(DIST_W'(int'($urandom_range(131072, 0)) - 65536));
            2:       plan_q.push_back(DIST_MIN);
            default: plan_q.push_back(DIST_MAX);
          endcase
        end
      end

      // One setting runs with the receiver held off while items keep coming.
      if (p == PRESSURE_SETTING) hold_off_reqs++;
      send_queued(p == PRESSURE_SETTING);
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    $display("Checked %0d results from %0d distance transfers over %0d limit settings,",
             results_checked, items_sent, SETTINGS_COUNT + 1);
    $display("with extreme and out-of-range limits, a long output hold-off and full drains.");
    if (fail_count == 0 && pending == 0) begin
      $display("delay_compensated_time_optimal_speed_test: PASS");
    end else begin
      $display("delay_compensated_time_optimal_speed_test: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/dcto_pkg.sv
rtl/dcto_in_if.sv
rtl/dcto_out_if.sv
rtl/dcto_ctrl.sv
rtl/dcto_datapath.sv
rtl/delay_compensated_time_optimal_speed.sv
sim/delay_compensated_time_optimal_speed_checker.sv
sim/delay_compensated_time_optimal_speed_test.sv
